@@ design/pdtd_pkg.sv @@
`timescale 1ns / 1ps
package pdtd_pkg;

   localparam int CntW       = 16;
   localparam int QuoW       = 13;
   localparam int NumW       = CntW + QuoW;
   localparam int TempW      = 13;
   localparam int TicksW     = 16;
   localparam int TimeW      = 16;
   localparam int StatW      = 2;
   localparam int TempScale  = 6400;
   localparam int TempOffset = 3760;
   localparam int TempMin    = -4096;
   localparam int SatLimit   = TempOffset - TempMin;

   typedef enum logic [StatW-1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_ZERO = 2'd2
   } status_type;

endpackage

@@ design/pwm_duty_temperature_decoder.sv @@
`timescale 1ns / 1ps
// A completing edge goes from its input transfer through ST_MUL, ST_CHECK,
// ST_DIV and ST_DONE to rsp_valid; ST_DIV is skipped for a zero low period or
// a quotient that overflows 13 bits. The bit-serial restoring divider retires
// one quotient bit per cycle; req_stall holds new edges until the result is
// loaded. Synchronous active-high reset clears the edge history, the period
// flags, the sequencer and the result valid flag.
module pwm_duty_temperature_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pdtd_pkg::TimeW-1:0] req_capture_time,
   input  logic                       req_pin_level,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [pdtd_pkg::TempW-1:0] rsp_temperature,
   output logic [pdtd_pkg::StatW-1:0]  rsp_status,
   output logic [pdtd_pkg::TicksW-1:0] rsp_high_ticks,
   output logic [pdtd_pkg::TicksW-1:0] rsp_low_ticks
);
   import pdtd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam int CntBits = $clog2(QuoW + 1);
   localparam logic [NumW-1:0] ScaleC = NumW'(TempScale);
   localparam logic [QuoW:0]   OffsetC = (QuoW + 1)'(TempOffset);
   localparam logic [QuoW-1:0] SatC    = QuoW'(SatLimit);

   state_type           state_ff, state_in;
   logic [CntW-1:0]     last_ff, last_in;
   logic [CntW-1:0]     high_ff, high_in;
   logic [CntW-1:0]     low_ff, low_in;
   logic                have_high_ff, have_high_in;
   logic                have_low_ff, have_low_in;
   logic [NumW-1:0]     rem_ff, rem_in;
   logic [NumW-1:0]     div_ff, div_in;
   logic [QuoW-1:0]     quo_ff, quo_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   status_type          stat_ff, stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [TempW-1:0] temp_ff, temp_in;
   status_type          ostat_ff, ostat_in;
   logic [TicksW-1:0]   ohigh_ff, ohigh_in;
   logic [TicksW-1:0]   olow_ff, olow_in;

   logic                req_xfer;
   logic [CntW-1:0]     now;
   logic [CntW-1:0]     span;
   logic                sub_ok;
   logic [QuoW:0]       diff;
   logic                load;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign now       = CntW'(req_capture_time);
   assign span      = now - last_ff;
   assign sub_ok    = (rem_ff >= div_ff);
   assign diff      = OffsetC - {1'b0, quo_ff};
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      have_high_in = have_high_ff;
      have_low_in  = have_low_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      stat_in      = stat_ff;
      temp_in      = temp_ff;
      ostat_in     = ostat_ff;
      ohigh_in     = ohigh_ff;
      olow_in      = olow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               last_in = now;
               if (req_pin_level) begin
                  low_in      = span;
                  have_low_in = 1'b1;
                  if (have_high_ff) begin
                     state_in = ST_MUL;
                  end
               end else begin
                  high_in      = span;
                  have_high_in = 1'b1;
                  if (have_low_ff) begin
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            have_high_in = 1'b0;
            have_low_in  = 1'b0;
            rem_in       = NumW'(high_ff) * ScaleC;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            div_in = NumW'(low_ff) << (QuoW - 1);
            quo_in = '0;
            cnt_in = '0;
            priority if (low_ff == '0) begin
               stat_in  = STAT_ZERO;
               state_in = ST_DONE;
            end else if (rem_ff >= (NumW'(low_ff) << QuoW)) begin
               stat_in  = STAT_SAT;
               state_in = ST_DONE;
            end else begin
               stat_in  = STAT_OK;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sub_ok) begin
               rem_in = rem_ff - div_ff;
            end
            quo_in = {quo_ff[QuoW-2:0], sub_ok};
            div_in = div_ff >> 1;
            cnt_in = cnt_ff + CntBits'(1);
            if (cnt_ff == CntBits'(QuoW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               ohigh_in     = TicksW'(high_ff);
               olow_in      = TicksW'(low_ff);
               unique case (stat_ff)
                  STAT_ZERO: begin
                     temp_in  = '0;
                     ostat_in = STAT_ZERO;
                  end
                  STAT_SAT: begin
                     temp_in  = TempW'(TempMin);
                     ostat_in = STAT_SAT;
                  end
                  default: begin
                     if (quo_ff > SatC) begin
                        temp_in  = TempW'(TempMin);
                        ostat_in = STAT_SAT;
                     end else begin
                        temp_in  = TempW'(diff);
                        ostat_in = STAT_OK;
                     end
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         have_high_ff <= 1'b0;
         have_low_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         have_high_ff <= have_high_in;
         have_low_ff  <= have_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      stat_ff  <= stat_in;
      temp_ff  <= temp_in;
      ostat_ff <= ostat_in;
      ohigh_ff <= ohigh_in;
      olow_ff  <= olow_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_status      = ostat_ff;
   assign rsp_high_ticks  = ohigh_ff;
   assign rsp_low_ticks   = olow_ff;

endmodule

@@ design/pdtd_checker.sv @@
`timescale 1ns / 1ps
module pdtd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [pdtd_pkg::TimeW-1:0] req_capture_time,
   input logic                       req_pin_level,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [pdtd_pkg::TempW-1:0] rsp_temperature,
   input logic [pdtd_pkg::StatW-1:0]  rsp_status,
   input logic [pdtd_pkg::TicksW-1:0] rsp_high_ticks,
   input logic [pdtd_pkg::TicksW-1:0] rsp_low_ticks
);
   import pdtd_pkg::*;

   // stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_status) && $stable(rsp_high_ticks) && $stable(rsp_low_ticks))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_zero_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_ZERO |-> rsp_temperature == '0 && rsp_low_ticks == '0)
      else $error("zero low period result malformed");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_SAT |-> rsp_temperature == TempW'(TempMin))
      else $error("saturated result not at minimum");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OK |-> rsp_temperature <= TempW'(TempOffset))
      else $error("temperature above offset");

endmodule

bind pwm_duty_temperature_decoder pdtd_checker u_pdtd_checker (.*);
